>>> hdl/pws_pkg.sv
// Shared types, constants and helpers of the pileup window separator.
package pws_pkg;

  localparam int unsigned WIN_W       = 10;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned IN_SAMPLE_W = 16;
  localparam int unsigned TDATA_W     = 24;
  localparam int unsigned MAX_WINDOW  = 1023;

  localparam logic [WIN_W-1:0] LEFT_RESET  = 10'd30;
  localparam logic [WIN_W-1:0] RIGHT_RESET = 10'd100;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 2'd1;

  // command queue between front and back
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;
  localparam int unsigned CMD_CNT_W = 3;

  typedef logic [POS_W-1:0] pos_t;

  // one classified beat: delay line write, span update and emit request
  typedef struct packed {
    logic                   we;
    logic                   emit;
    logic                   add;
    logic                   clip;
    pos_t                   lo;
    pos_t                   hi;     // span end, or clip end
    logic                   trig;
    logic                   last;
    logic [IN_SAMPLE_W-1:0] sample;
  } pws_cmd_t;

  // a <= b in wrapping stream positions
  function automatic logic not_after(pos_t a, pos_t b);
    pos_t d;
    d = b - a;
    return ~d[POS_W-1];
  endfunction

  function automatic logic [WIN_W-1:0] sat_window(logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    r = v;
    if (32'(v) > MAX_WINDOW) r = WIN_W'(MAX_WINDOW);
    return r;
  endfunction

endpackage

>>> hdl/pws_cmd_fifo.sv
// Short command queue that decouples the classifier from the emitter.
module pws_cmd_fifo import pws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pws_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output pws_cmd_t head_cmd,
  output logic     not_empty
);

  pws_cmd_t             slot_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r;
  logic [CMD_PTR_W-1:0] rd_ptr_r;
  logic [CMD_CNT_W-1:0] cnt_r;
  logic [CMD_CNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hdl/pws_front.sv
// Classifier: takes beats, tracks triggers, forms spans and decides emits.
module pws_front import pws_pkg::*; #(
  parameter int unsigned DELAY_DEPTH = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_flush,
  input  logic [IN_SAMPLE_W-1:0] in_sample,
  input  logic                   in_trig,
  input  logic                   in_last,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [WIN_W-1:0]       cfg_data,
  input  logic                   fifo_full,
  output logic                   cmd_push,
  output pws_cmd_t               cmd
);

  localparam int unsigned BW = $clog2(DELAY_DEPTH);
  localparam pos_t DELAY_CAP = POS_W'(DELAY_DEPTH - 1);

  logic [WIN_W-1:0] left_r;
  logic [WIN_W-1:0] right_r;
  pos_t             pos_r;
  pos_t             prev_r;
  pos_t             tstart_r;
  logic             seen_r;
  logic [BW-1:0]    buf_r;

  pos_t             pos_nxt;
  pos_t             prev_nxt;
  pos_t             tstart_nxt;
  logic             seen_nxt;
  logic [BW-1:0]    buf_nxt;

  logic [WIN_W:0]   pair_gap;
  logic [WIN_W+1:0] dly_raw;
  pos_t             dly;
  pos_t             off;
  pos_t             lo;
  logic             close;
  logic             accept;
  logic             emit;

  assign in_ready = ~fifo_full;
  assign accept   = in_valid & ~fifo_full;

  always_comb begin
    pair_gap = {1'b0, left_r} + {1'b0, right_r};
    dly_raw  = ((WIN_W+2)'(left_r) << 1) + (WIN_W+2)'(right_r);
    dly      = (POS_W'(dly_raw) > DELAY_CAP) ? DELAY_CAP : POS_W'(dly_raw);
    close    = seen_r && ((pos_r - prev_r) < POS_W'(pair_gap));
    off      = prev_r - tstart_r;
    lo       = (off < POS_W'(left_r)) ? tstart_r : prev_r - POS_W'(left_r);

    cmd        = '0;
    cmd.sample = in_sample;
    cmd.trig   = in_trig;
    cmd.last   = in_last;
    emit       = 1'b0;

    pos_nxt    = pos_r;
    prev_nxt   = prev_r;
    tstart_nxt = tstart_r;
    seen_nxt   = seen_r;
    buf_nxt    = buf_r;

    if (in_flush) begin
      // drain one buffered sample, nothing if the line is empty
      emit = (buf_r != '0);
      if (emit) buf_nxt = buf_r - 1'b1;
    end else begin
      cmd.we = 1'b1;
      emit   = (POS_W'(buf_r) >= dly);
      if (!emit) buf_nxt = buf_r + 1'b1;
      if (in_trig && !in_last) begin
        cmd.add  = close;
        cmd.lo   = lo;
        cmd.hi   = pos_r + POS_W'(right_r);
        prev_nxt = pos_r;
        seen_nxt = 1'b1;
      end
      if (in_last) begin
        cmd.clip   = 1'b1;
        cmd.hi     = pos_r + 1'b1;
        seen_nxt   = 1'b0;
        tstart_nxt = pos_r + 1'b1;
      end
      pos_nxt = pos_r + 1'b1;
    end
    cmd.emit = emit;
    cmd_push = accept && (cmd.we || emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= LEFT_RESET;
      right_r  <= RIGHT_RESET;
      pos_r    <= '0;
      prev_r   <= '0;
      tstart_r <= '0;
      seen_r   <= 1'b0;
      buf_r    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LEFT:  left_r  <= sat_window(cfg_data);
          CFG_RIGHT: right_r <= sat_window(cfg_data);
          default: ;
        endcase
      end
      if (accept) begin
        pos_r    <= pos_nxt;
        prev_r   <= prev_nxt;
        tstart_r <= tstart_nxt;
        seen_r   <= seen_nxt;
        buf_r    <= buf_nxt;
      end
    end
  end

endmodule

>>> hdl/pws_back.sv
// Emitter: delay line memory, span queue and the registered result beat.
module pws_back import pws_pkg::*; #(
  parameter int unsigned DELAY_DEPTH    = 4096,
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned INTERVAL_SLOTS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  pws_cmd_t               cmd,
  output logic                   cmd_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IN_SAMPLE_W-1:0] out_sample,
  output logic                   out_trig,
  output logic                   out_mark,
  output logic                   out_last
);

  localparam int unsigned SW = (SAMPLE_BITS < IN_SAMPLE_W) ? SAMPLE_BITS : IN_SAMPLE_W;
  localparam int unsigned EW = SW + 2;
  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned N  = INTERVAL_SLOTS;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DELAY_DEPTH - 1);

  logic [EW-1:0] mem [DELAY_DEPTH];
  logic [EW-1:0] mem_q_r;
  logic [EW-1:0] byp_data_r;
  logic          byp_r;
  logic          mark_r;
  logic          out_valid_r;
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  pos_t          emit_pos_r;

  pos_t          slot_lo_r [N];
  pos_t          slot_hi_r [N];
  logic [IW-1:0] head_r;
  logic [CW-1:0] cnt_r;

  pos_t          lo_a [N];
  pos_t          hi_a [N];
  logic [CW-1:0] cnt_a;
  logic [N-1:0]  stale;
  logic [CW-1:0] pops;
  logic [IW-1:0] head_nxt;
  logic [CW-1:0] cnt_nxt;
  logic          mark;
  logic          go;
  logic [EW-1:0] wdata;
  logic [EW-1:0] entry;

  assign wdata = {cmd.last, cmd.trig, cmd.sample[SW-1:0]};
  assign go    = cmd_valid && (!cmd.emit || !out_valid_r || out_ready);
  assign cmd_pop = go;

  always_comb begin
    int s;
    logic [IW-1:0] last_i;
    logic [IW-1:0] tail_i;
    logic [IW-1:0] idx;
    logic found;

    for (int i = 0; i < N; i++) begin
      lo_a[i] = slot_lo_r[i];
      hi_a[i] = slot_hi_r[i];
    end
    cnt_a = cnt_r;

    s = int'(head_r) + int'(cnt_r) - 1;
    if (s < 0) s = s + N;
    if (s >= N) s = s - N;
    last_i = IW'(s);
    s = int'(head_r) + int'(cnt_r);
    if (s >= N) s = s - N;
    tail_i = IW'(s);

    // add a span: extend the newest one when it overlaps or the queue is full
    if (cmd.add) begin
      if (cnt_r != '0 &&
          (not_after(cmd.lo, slot_hi_r[last_i]) || cnt_r == CW'(N))) begin
        if (not_after(slot_hi_r[last_i], cmd.hi)) hi_a[last_i] = cmd.hi;
      end else begin
        lo_a[tail_i] = cmd.lo;
        hi_a[tail_i] = cmd.hi;
        cnt_a        = cnt_r + 1'b1;
      end
    end

    // trace end: cut every span back to it (free slots are harmless)
    if (cmd.clip) begin
      for (int i = 0; i < N; i++) begin
        if (not_after(cmd.hi, hi_a[i])) hi_a[i] = cmd.hi;
      end
    end

    for (int i = 0; i < N; i++) stale[i] = not_after(hi_a[i], emit_pos_r);

    // drop the leading spans that end at or before the emitted position
    pops  = cnt_a;
    found = 1'b0;
    for (int k = 0; k < N; k++) begin
      s = int'(head_r) + k;
      if (s >= N) s = s - N;
      idx = IW'(s);
      if (!found && (CW'(k) < cnt_a) && !stale[idx]) begin
        found = 1'b1;
        pops  = CW'(k);
      end
    end
    s = int'(head_r) + int'(pops);
    if (s >= N) s = s - N;
    head_nxt = IW'(s);
    cnt_nxt  = cnt_a - pops;
    mark     = (cnt_nxt != '0) && not_after(lo_a[head_nxt], emit_pos_r);
  end

  always_ff @(posedge clk) begin
    if (go && cmd.we) mem[wr_ptr_r] <= wdata;
    if (go && cmd.emit) begin
      mem_q_r    <= mem[rd_ptr_r];
      byp_data_r <= wdata;
      byp_r      <= cmd.we && (rd_ptr_r == wr_ptr_r);
      mark_r     <= mark;
    end
    if (go) begin
      for (int i = 0; i < N; i++) begin
        slot_lo_r[i] <= lo_a[i];
        slot_hi_r[i] <= hi_a[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      emit_pos_r  <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
    end else begin
      if (go) begin
        if (cmd.we) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
        if (cmd.emit) begin
          rd_ptr_r   <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
          emit_pos_r <= emit_pos_r + 1'b1;
          head_r     <= head_nxt;
          cnt_r      <= cnt_nxt;
        end else begin
          cnt_r <= cnt_a;
        end
      end
      if (go && cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign entry      = byp_r ? byp_data_r : mem_q_r;
  assign out_valid  = out_valid_r;
  assign out_sample = IN_SAMPLE_W'(entry[SW-1:0]);
  assign out_trig   = entry[SW];
  assign out_last   = entry[SW+1];
  assign out_mark   = mark_r;

endmodule

>>> hdl/pileup_window_separator.sv
// Top level of the pileup window separator: front, command queue and back.
//
// Input stream (in_*): one beat per trace sample or flush tick. in_tuser = 1
// marks a flush tick, which drains one buffered sample and ignores the rest.
// in_tlast marks the final sample of a trace; its trigger is ignored.
// Output stream (out_*): each sample comes back cut to SAMPLE_BITS, delayed by
// 2*left + right samples (capped at DELAY_DEPTH - 1), with out_tuser = 1 when
// it falls inside a pileup span and out_tlast on the final trace sample.
// Config (cfg_*): register 0 is the left window, 1 the right window; always
// ready. The user must write it only while the block is idle; the block does not
// enforce this. Reset values are 30 and 100. Throughput is one beat per cycle on
// both sides while nothing stalls. The beat that releases a result enters the
// command queue; the back reads the delay line when it pops that command, then
// raises out_tvalid. When out_tready is low the back holds its result and stalls
// at its next emit command; the front keeps accepting into the four-entry command
// queue, then drops in_tready. Reset clears counters, span queue and config; the
// delay line memory is not cleared, since an entry is only read after it is written.
module pileup_window_separator import pws_pkg::*; #(
  parameter int unsigned DELAY_DEPTH    = 4096,
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned INTERVAL_SLOTS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [TDATA_W-1:0]   in_tdata,   // sample[15:0], trigger[16], zero pad
  input  logic                 in_tuser,   // action (1 = flush)
  input  logic                 in_tlast,   // end_of_trace
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TDATA_W-1:0]   out_tdata,  // out_sample[15:0], out_trigger[16], zero pad
  output logic                 out_tuser,  // pileup
  output logic                 out_tlast,  // final_res
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_W-1:0]     cfg_data
);

  pws_cmd_t               push_cmd;
  pws_cmd_t               head_cmd;
  logic                   cmd_push;
  logic                   cmd_pop;
  logic                   fifo_full;
  logic                   fifo_not_empty;
  logic [IN_SAMPLE_W-1:0] res_sample;
  logic                   res_trig;

  assign cfg_ready = 1'b1;

  // classify beats and turn them into commands
  pws_front #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_flush  (in_tuser),
    .in_sample (in_tdata[IN_SAMPLE_W-1:0]),
    .in_trig   (in_tdata[IN_SAMPLE_W]),
    .in_last   (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fifo_full (fifo_full),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd)
  );

  // hold commands so either side can stall on its own
  pws_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (cmd_pop),
    .head_cmd  (head_cmd),
    .not_empty (fifo_not_empty)
  );

  // store samples, track spans, emit marked results
  pws_back #(
    .DELAY_DEPTH    (DELAY_DEPTH),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .INTERVAL_SLOTS (INTERVAL_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (fifo_not_empty),
    .cmd        (head_cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (res_sample),
    .out_trig   (res_trig),
    .out_mark   (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{(TDATA_W-IN_SAMPLE_W-1){1'b0}}, res_trig, res_sample};

endmodule
